// File: src/srr_pkg.sv
// ---------------------------------------------------------------------------
// srr_pkg: shared constants, types and helpers for the railcar reorder block
// Holds the stack size, field widths, controller/datapath interface structs
// and the saturating counter helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int MAX_CARS = 256;
    localparam int SP_W     = $clog2(MAX_CARS + 1);
    localparam int ADDR_W   = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CAR_W    = 9;
    localparam int MOVE_W   = 10;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 64;

    localparam logic [SP_W-1:0] SP_FULL = SP_W'(MAX_CARS);

    // Controller to datapath commands.
    typedef struct packed {
        logic take;      // latch the arriving item and do the push or release
        logic pop;       // pop the matching top, start reading the entry below
        logic load_top;  // capture the read data as the new stack top
        logic emit;      // load the result register, clear on the last car
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic top_match;  // stack not empty and its top equals the wanted number
        logic more_below; // at least two cars on the stack
        logic out_free;   // result register can take a new item
    } t_sts;

    function automatic logic [CAR_W-1:0] inc_sat9(input logic [CAR_W-1:0] v);
        inc_sat9 = (v == {CAR_W{1'b1}}) ? v : v + CAR_W'(1);
    endfunction

    function automatic logic [MOVE_W-1:0] inc_sat10(input logic [MOVE_W-1:0] v);
        inc_sat10 = (v == {MOVE_W{1'b1}}) ? v : v + MOVE_W'(1);
    endfunction

    // Clamp a depth value to the 9-bit result field.
    function automatic logic [CAR_W-1:0] clamp9(input logic [SP_W-1:0] v);
        logic [SP_W+CAR_W-1:0] wide;
        wide = (SP_W + CAR_W)'(v);
        clamp9 = (wide > (SP_W + CAR_W)'(511)) ? {CAR_W{1'b1}} : wide[CAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/stack_railcar_reorder_core.sv
// ---------------------------------------------------------------------------
// stack_railcar_reorder_core: railcar reordering through one holding stack
// Cars arrive one per item; matching cars leave at once, others wait on the
// stack and leave as soon as they become the wanted number.
// ---------------------------------------------------------------------------
//   Channel  Dir  Handshake               Payload
//   s_axis   in   tvalid/tready           tdata: car_number; tlast: last_car
//   m_axis   out  tvalid/tready           tdata: result fields; tlast: train_done
//
// An item is taken in the idle step, then checked; every car popped from the
// holding stack passes a load step that waits on the registered read of the
// stack RAM, except a pop that empties the stack, which needs no read. Each
// car is popped at most once. A new car is accepted only back in the idle step.
// Reset (synchronous, active low) empties the stack and clears the train counters.
// A stalled output holds the block in its final step until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module stack_railcar_reorder_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [8:0] car_number, [15:9] zero
    input  wire logic [srr_pkg::IN_W-1:0]  s_axis_tdata,
    input  wire logic                      s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [8:0] cars_released, [17:9] hold_depth, [26:18] next_wanted,
    // [36:27] move_count, [45:37] max_hold_depth, [46] success,
    // [47] overflow, [56:48] car_total, [63:57] zero
    output logic      [srr_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import srr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    srr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_car      (s_axis_tdata[CAR_W-1:0]),
        .i_last     (s_axis_tlast),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

    // No car is accepted in the cycle right after an accepted car.
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in back-to-back cycles");

    // Success is only reported on the last car of a train.
    a_success_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[46] |-> m_axis_tlast)
        else $error("success flagged without train_done");

    // The deepest depth seen never falls below the current depth.
    a_deepest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[45:37] >= m_axis_tdata[17:9])
        else $error("max_hold_depth below hold_depth");

    // No two datapath commands (take, pop, load_top, emit) are given together.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.take, w_cmd.pop, w_cmd.load_top, w_cmd.emit}) <= 1)
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire

// File: src/srr_ram.sv
// ---------------------------------------------------------------------------
// srr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/srr_ctrl.sv
// ---------------------------------------------------------------------------
// srr_ctrl: sequencer for the railcar reorder block
// Accepts one car, then runs the pop loop until the stack top no longer
// matches, and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire srr_pkg::t_sts i_sts,
    output srr_pkg::t_cmd      o_cmd
);
    import srr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.top_match) begin
                    o_cmd.pop = 1'b1;
                    // With one car left the stack empties and no read is needed.
                    if (i_sts.more_below) begin
                        n_state = ST_LOAD;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_LOAD: begin
                o_cmd.load_top = 1'b1;
                n_state        = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: src/srr_dpath.sv
// ---------------------------------------------------------------------------
// srr_dpath: datapath of the railcar reorder block
// Holding stack in RAM with the top cached in a register, the train
// counters, and the output result register.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire srr_pkg::t_cmd                i_cmd,
    output srr_pkg::t_sts                     o_sts,
    input  wire logic [srr_pkg::CAR_W-1:0]    i_car,
    input  wire logic                         i_last,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic      [srr_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast
);
    import srr_pkg::*;

    logic [SP_W-1:0]   r_sp;
    logic [CAR_W-1:0]  r_wanted;
    logic [MOVE_W-1:0] r_moves;
    logic [SP_W-1:0]   r_deepest;
    logic [CAR_W-1:0]  r_seen;
    logic              r_ovf;
    logic [CAR_W-1:0]  r_top;
    logic [CAR_W-1:0]  r_released;
    logic              r_last;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic              w_match;
    logic              w_push;
    logic [SP_W-1:0]   w_sp_inc;
    logic [SP_W-1:0]   w_sp_dec2;
    logic [CAR_W-1:0]  w_rdata;
    logic              w_success;
    logic [CAR_W:0]    w_seen_p1;

    assign w_match   = (i_car == r_wanted);
    assign w_push    = i_cmd.take && !w_match && (r_sp < SP_FULL);
    assign w_sp_inc  = r_sp + SP_W'(1);
    assign w_sp_dec2 = r_sp - SP_W'(2);

    srr_ram #(
        .WIDTH (CAR_W),
        .DEPTH (MAX_CARS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_sp[ADDR_W-1:0]),
        .i_wdata (i_car),
        .i_re    (i_cmd.pop),
        .i_raddr (w_sp_dec2[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_sts.top_match  = (r_sp != '0) && (r_top == r_wanted);
    assign o_sts.more_below = (r_sp >= SP_W'(2));
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign w_seen_p1 = {1'b0, r_seen} + (CAR_W + 1)'(1);
    assign w_success = r_last && !r_ovf && ({1'b0, r_wanted} == w_seen_p1);

    // Train state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_wanted  <= CAR_W'(1);
            r_moves   <= '0;
            r_deepest <= '0;
            r_seen    <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.take) begin
            r_seen <= inc_sat9(r_seen);
            if (w_match) begin
                r_wanted <= inc_sat9(r_wanted);
            end else if (!w_push) begin
                r_ovf <= 1'b1;
            end else begin
                r_sp    <= w_sp_inc;
                r_moves <= inc_sat10(r_moves);
                if (w_sp_inc > r_deepest) begin
                    r_deepest <= w_sp_inc;
                end
            end
        end else if (i_cmd.pop) begin
            r_sp     <= r_sp - SP_W'(1);
            r_wanted <= inc_sat9(r_wanted);
            r_moves  <= inc_sat10(r_moves);
        end else if (i_cmd.emit && r_last) begin
            r_sp      <= '0;
            r_wanted  <= CAR_W'(1);
            r_moves   <= '0;
            r_deepest <= '0;
            r_seen    <= '0;
            r_ovf     <= 1'b0;
        end
    end

    // Per-item payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_last     <= i_last;
            r_released <= w_match ? CAR_W'(1) : '0;
            if (w_push) begin
                r_top <= i_car;
            end
        end else if (i_cmd.pop) begin
            r_released <= inc_sat9(r_released);
        end else if (i_cmd.load_top) begin
            r_top <= w_rdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= r_last;
            r_out_data <= {7'b0, r_seen, r_ovf, w_success, clamp9(r_deepest),
                           r_moves, r_wanted, clamp9(r_sp), r_released};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
